// ===== hdl/tess_pkg.sv =====
// Shared opcodes, status codes and controller command type for the two-ended stack.
package tess_pkg;

    localparam logic [1:0] OP_PUSH_RIGHT = 2'd0;
    localparam logic [1:0] OP_PUSH_LEFT  = 2'd1;
    localparam logic [1:0] OP_POP_RIGHT  = 2'd2;
    localparam logic [1:0] OP_POP_LEFT   = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam int USED_BITS = 5;

    typedef struct packed {
        logic capture;   // latch the incoming transaction
        logic execute;   // perform the operation on store and counts
    } tess_cmd_t;

endpackage

// ===== hdl/tess_ctrl.sv =====
// Sequencing state machine for the two-ended stack: accept, execute, respond.
module tess_ctrl
    import tess_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    output tess_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = (state_reg == S_RESP);
    assign cmd.capture = in_valid && (state_reg == S_IDLE);
    assign cmd.execute = (state_reg == S_EXEC);

endmodule

// ===== hdl/tess_dpath.sv =====
// Datapath: word store, the two stack counts and the result registers.
module tess_dpath
    import tess_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tess_cmd_t            cmd,
    input  logic [1:0]           opcode,
    input  logic signed [31:0]   push_value,
    output logic signed [31:0]   pop_value,
    output logic [1:0]           status,
    output logic [USED_BITS-1:0] entries_used
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [CW-1:0] TOP_IDX = CW'(DEPTH - 1);

    logic [WORD_BITS-1:0] mem [DEPTH];

    logic [1:0]           op_reg;
    logic [31:0]          val_reg;
    logic [CW-1:0]        left_count_reg;
    logic [CW-1:0]        left_count_next;
    logic [CW-1:0]        right_count_reg;
    logic [CW-1:0]        right_count_next;
    logic [1:0]           status_reg;
    logic [1:0]           status_next;
    logic                 pop_ok_reg;
    logic                 pop_ok_next;
    logic [WORD_BITS-1:0] rd_data_reg;

    logic                 wr_en;
    logic                 rd_en;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        rd_addr;
    logic [SW-1:0]        used_sum;
    logic                 full;
    logic [CW-1:0]        left_dec;
    logic [CW-1:0]        right_dec;
    logic [CW-1:0]        right_push_idx;
    logic [CW-1:0]        right_pop_idx;

    assign used_sum       = SW'(left_count_reg) + SW'(right_count_reg);
    assign full           = (used_sum >= SW'(DEPTH));
    assign left_dec       = left_count_reg - CW'(1);
    assign right_dec      = right_count_reg - CW'(1);
    assign right_push_idx = TOP_IDX - right_count_reg;
    assign right_pop_idx  = TOP_IDX - right_dec;

    always_comb
    begin
        left_count_next  = left_count_reg;
        right_count_next = right_count_reg;
        status_next      = ST_DONE;
        pop_ok_next      = 1'b0;
        wr_en            = 1'b0;
        rd_en            = 1'b0;
        wr_addr          = left_count_reg[AW-1:0];
        rd_addr          = left_dec[AW-1:0];
        case (op_reg)
            OP_PUSH_RIGHT:
            begin
                wr_addr = right_push_idx[AW-1:0];
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    wr_en            = 1'b1;
                    right_count_next = right_count_reg + CW'(1);
                end
            end
            OP_PUSH_LEFT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    wr_en           = 1'b1;
                    left_count_next = left_count_reg + CW'(1);
                end
            end
            OP_POP_RIGHT:
            begin
                rd_addr = right_pop_idx[AW-1:0];
                if (right_count_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    rd_en            = 1'b1;
                    pop_ok_next      = 1'b1;
                    right_count_next = right_dec;
                end
            end
            OP_POP_LEFT:
            begin
                if (left_count_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    rd_en           = 1'b1;
                    pop_ok_next     = 1'b1;
                    left_count_next = left_dec;
                end
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    // transaction payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= opcode;
            val_reg <= push_value;
        end
    end

    // store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.execute && wr_en)
        begin
            mem[wr_addr] <= WORD_BITS'(val_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute && rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_count_reg  <= '0;
            right_count_reg <= '0;
            status_reg      <= ST_DONE;
            pop_ok_reg      <= 1'b0;
        end
        else if (cmd.execute)
        begin
            left_count_reg  <= left_count_next;
            right_count_reg <= right_count_next;
            status_reg      <= status_next;
            pop_ok_reg      <= pop_ok_next;
        end
    end

    assign pop_value    = pop_ok_reg ? 32'(rd_data_reg) : '0;
    assign status       = status_reg;
    assign entries_used = USED_BITS'(used_sum);

    a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        used_sum <= SW'(DEPTH))
        else $error("stack counts exceed store depth");

endmodule

// ===== hdl/two_ended_shared_stack_unit.sv =====
// Top level of the two-ended shared stack unit.
//
// Two stacks share one store of DEPTH words: the left stack grows up from
// entry 0, the right stack grows down from entry DEPTH-1.
// Input channel: in_valid / in_stall carries opcode (push right, push left,
// pop right, pop left) and push_value. Output channel: out_valid / out_stall
// carries pop_value, status (done, full, empty) and entries_used.
// Each transaction gives exactly one result.
// A transaction is captured, then executed against the store with a registered
// read, and its result is then shown in the response state. One transaction is
// in flight at a time; the unit takes no new transaction until the result is
// handed off, so each one steps through accept, execute and result handoff.
// While the result waits under out_stall it holds steady and in_stall stays
// high; the unit takes the next transaction once the result is taken.
// Reset clears both stack counts, so both sides read as empty. The store
// itself is not cleared; only entries written by a push are ever read.
// A refused push (store full) or pop (side empty) leaves the counts and the
// store unchanged and returns pop_value zero.
module two_ended_shared_stack_unit
    import tess_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           opcode,
    input  logic signed [31:0]   push_value,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [31:0]   pop_value,
    output logic [1:0]           status,
    output logic [USED_BITS-1:0] entries_used
);

    tess_cmd_t cmd;

    // sequencer: owns both handshakes
    tess_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // store, counts and result registers
    tess_dpath #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .opcode       (opcode),
        .push_value   (push_value),
        .pop_value    (pop_value),
        .status       (status),
        .entries_used (entries_used)
    );

    // one transaction at a time: never open for input while a result is shown
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !out_valid)
        else $error("input open while result pending");

    // an accepted transaction is answered once its execute state has passed
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> ##1 out_valid)
        else $error("result missing after accepted transaction");

    // refused push only when both stacks fill the store
    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_FULL)) |-> (entries_used == USED_BITS'(DEPTH)))
        else $error("full status with free entries");

    // a failed operation never returns data
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_DONE)) |-> (pop_value == '0))
        else $error("refused operation returned data");

endmodule

// ===== tb/stack_checker.sv =====
// Checker for the two-ended shared stack: predicts each transaction's result and compares.
`timescale 1ns / 1ps

module stack_checker
    import tess_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [1:0]           opcode,
    input  logic signed [31:0]   push_value,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic signed [31:0]   pop_value,
    input  logic [1:0]           status,
    input  logic [USED_BITS-1:0] entries_used,
    output int                   error_count,
    output int                   pending
);

    typedef struct {
        logic signed [31:0]   value;
        logic [1:0]           code;
        logic [USED_BITS-1:0] used;
    } stack_result_t;

    logic [31:0]   shadow_store [DEPTH];
    int            left_depth;
    int            right_depth;
    stack_result_t expected_results [$];

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] stack mismatch on %s: got %0h, expected %0h", $realtime, what, got,
                 want);
        error_count++;
    endtask

    // Applies one operation to the shadow stacks and returns the result it yields.
    function automatic stack_result_t predict_stack_op(logic [1:0] op, logic [31:0] val);
        stack_result_t r;
        logic          full;
        r.value = '0;
        r.code  = ST_DONE;
        full    = (left_depth + right_depth) >= DEPTH;
        case (op)
            OP_PUSH_RIGHT:
                if (full) r.code = ST_FULL;
                else
                begin
                    shadow_store[DEPTH - 1 - right_depth] = val;
                    right_depth++;
                end
            OP_PUSH_LEFT:
                if (full) r.code = ST_FULL;
                else
                begin
                    shadow_store[left_depth] = val;
                    left_depth++;
                end
            OP_POP_RIGHT:
                if (right_depth == 0) r.code = ST_EMPTY;
                else
                begin
                    right_depth--;
                    r.value = shadow_store[DEPTH - 1 - right_depth];
                end
            default:
                if (left_depth == 0) r.code = ST_EMPTY;
                else
                begin
                    left_depth--;
                    r.value = shadow_store[left_depth];
                end
        endcase
        r.used = USED_BITS'(left_depth + right_depth);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        stack_result_t want_r;
        if (!rst_n)
        begin
            left_depth  = 0;
            right_depth = 0;
            error_count = 0;
            expected_results.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", {30'd0, status}, '0);
                else
                begin
                    want_r = expected_results.pop_front();
                    if (pop_value !== want_r.value)
                        report_mismatch("pop_value", pop_value, want_r.value);
                    if (status !== want_r.code)
                        report_mismatch("status", {30'd0, status}, {30'd0, want_r.code});
                    if (entries_used !== want_r.used)
                        report_mismatch("entries_used", 32'(entries_used), 32'(want_r.used));
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(predict_stack_op(opcode, push_value));
            pending <= expected_results.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// Top of the two-ended shared stack testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
    import tess_pkg::*;

    localparam int STACK_DEPTH  = 16;
    localparam int RANDOM_OPS   = 1830;
    localparam int CYCLE_LIMIT  = 400000;
    // Long receiver hold-offs land at these result counts.
    localparam int HOLD_AT_A    = 400;
    localparam int HOLD_AT_B    = 1300;
    localparam int HOLD_CYCLES  = 200;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 in_valid     = 1'b0;
    logic [1:0]           opcode       = OP_PUSH_RIGHT;
    logic signed [31:0]   push_value   = '0;
    logic                 out_stall    = 1'b0;
    logic                 in_stall;
    logic                 out_valid;
    logic signed [31:0]   pop_value;
    logic [1:0]           status;
    logic [USED_BITS-1:0] entries_used;

    int error_count;
    int pending;
    int cycle_count   = 0;
    int sender_mode   = 0;
    int receiver_mode = 0;

    // 2 ns period.
    always #1 clk = ~clk;

    two_ended_shared_stack_unit #(.DEPTH(STACK_DEPTH), .WORD_BITS(32)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .push_value   (push_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pop_value    (pop_value),
        .status       (status),
        .entries_used (entries_used)
    );

    stack_checker #(.DEPTH(STACK_DEPTH)) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .push_value   (push_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pop_value    (pop_value),
        .status       (status),
        .entries_used (entries_used),
        .error_count  (error_count),
        .pending      (pending)
    );

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Idle cycles before the next transaction. Mode 0 gives back-to-back
    // stretches, mode 1 spreads gaps evenly, mode 2 has only occasional gaps.
    function automatic int pick_wait(int mode);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, 14);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
        endcase
    endfunction

    // Offers one transaction after a random gap and returns at the edge that
    // accepts it. in_valid stays high into the next call when the gap is zero,
    // so it is never dropped and re-raised in the same step.
    task automatic send_txn(logic [1:0] op, logic [31:0] val);
        int gap;
        gap = pick_wait(sender_mode);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        push_value <= val;
        do @(posedge clk); while (in_stall);
    endtask

    // Mostly random words, with the sign and all-ones corners mixed in.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Receiver: random stall before each result, plus two long hold-offs so
    // the unit backs up and holds in_stall while the sender keeps offering.
    initial
    begin
        int taken;
        int hold;
        taken = 0;
        @(posedge rst_n);
        forever
        begin
            if (taken % 32 == 0)
                receiver_mode = $urandom_range(0, 2);
            if (taken == HOLD_AT_A || taken == HOLD_AT_B)
                hold = HOLD_CYCLES;
            else
                hold = pick_wait(receiver_mode);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    // Sender and verdict.
    initial
    begin
        int push_pct;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: both sides empty, then fill the store from both ends
        // with the word extremes, refuse pushes on a full store, pop back.
        send_txn(OP_POP_RIGHT, 32'hffff_ffff);
        send_txn(OP_POP_LEFT,  32'h1234_5678);
        for (int i = 0; i < STACK_DEPTH / 2; i++)
        begin
            send_txn(OP_PUSH_LEFT,  (i % 2 == 0) ? 32'h8000_0000 : 32'hffff_ffff);
            send_txn(OP_PUSH_RIGHT, (i % 2 == 0) ? 32'h7fff_ffff : 32'h0000_0000);
        end
        send_txn(OP_PUSH_RIGHT, 32'hdead_beef);
        send_txn(OP_PUSH_LEFT,  32'h0bad_f00d);
        send_txn(OP_POP_LEFT,   32'h0);
        send_txn(OP_POP_RIGHT,  32'h0);
        send_txn(OP_POP_RIGHT,  32'h0);

        // Random: phases biased toward pushing or popping so the stacks keep
        // swinging between full and empty.
        push_pct = 50;
        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            if (n % 32 == 0)
                sender_mode = $urandom_range(0, 2);
            if (n % 40 == 0)
                case ($urandom_range(0, 2))
                    0:       push_pct = 85;
                    1:       push_pct = 50;
                    default: push_pct = 15;
                endcase
            if ($urandom_range(0, 99) < push_pct)
                send_txn($urandom_range(0, 1) ? OP_PUSH_LEFT : OP_PUSH_RIGHT, pick_word());
            else
                send_txn($urandom_range(0, 1) ? OP_POP_LEFT : OP_POP_RIGHT, pick_word());
        end
        in_valid <= 1'b0;

        // Drain: pending is a registered copy of the checker's queue size and lags it, so wait at least once.
        do @(posedge clk); while (pending != 0);
        repeat (10) @(posedge clk);

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/tess_pkg.sv
hdl/tess_ctrl.sv
hdl/tess_dpath.sv
hdl/two_ended_shared_stack_unit.sv
tb/stack_checker.sv
tb/tb.sv
